>>> src/mjpeg_frame_delimiter_top_assert.svh
// assertion macros for the mjpeg frame delimiter checker
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef MJPEG_FRAME_DELIMITER_TOP_ASSERT_SVH
`define MJPEG_FRAME_DELIMITER_TOP_ASSERT_SVH

// clocked check, masked while reset is asserted
`define MFD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("mfd checker: property failed");

// clocked check that also holds across reset
`define MFD_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("mfd checker: property failed");

`endif

>>> src/mfd_pkg.sv
// shared constants and types for the mjpeg frame delimiter
// used by every module of the block; depends on nothing
package mfd_pkg;

    localparam int LIMIT_W = 24;
    localparam int LEN_W   = 25;

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_SOI = 8'hD8;
    localparam logic [7:0] BYTE_EOI = 8'hD9;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = LIMIT_W'(2);
    localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0]   LEN_SOI     = LEN_W'(2);

    // output queue holds up to this many result items
    localparam int QUEUE_DEPTH = 3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       byte_valid;
        logic       frame_start;
        logic       frame_end;
        logic       frame_abort;
        logic       last_of_step;
    } t_result;

    // results produced by one input item, r0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

>>> src/mfd_in_reg.sv
// input register stage of the mjpeg frame delimiter
// holds one accepted byte until the core takes it; uses mfd_pkg
module mfd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import mfd_pkg::*;

    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       accept;

    // free when empty or when the core drains it this cycle
    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

>>> src/mfd_core.sv
// marker detection and frame length tracking of the mjpeg frame delimiter
// holds the frame state and the size limit register; uses mfd_pkg
module mfd_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [mfd_pkg::LIMIT_W-1:0]  i_cfg_wr_data,
    input  logic                         i_valid,
    input  logic [7:0]                   i_byte,
    input  logic                         i_space_ok,
    output logic                         o_take,
    output mfd_pkg::t_push               o_push
);
    import mfd_pkg::*;

    logic               r_in_frame, n_in_frame;
    logic               r_prev_ff, n_prev_ff;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic [LEN_W-1:0]   len_inc;
    logic               is_ff, is_soi, is_eoi, ends;
    t_push              push;

    // an item is taken only when the queue has room for two results
    assign o_take = i_valid && i_space_ok;

    assign is_ff   = (i_byte == BYTE_FF);
    assign is_soi  = (i_byte == BYTE_SOI);
    assign is_eoi  = (i_byte == BYTE_EOI);
    assign ends    = r_prev_ff && is_eoi;
    assign len_inc = (r_len != LEN_MAX) ? r_len + LEN_W'(1) : r_len;

    // limits below the minimum act as the minimum
    always_comb begin
        n_limit = r_limit;
        if (i_cfg_wr_en) begin
            n_limit = (i_cfg_wr_data < LIMIT_MIN) ? LIMIT_MIN : i_cfg_wr_data;
        end
    end

    // per-item state update and result build
    always_comb begin
        n_in_frame = r_in_frame;
        n_prev_ff  = r_prev_ff;
        n_len      = r_len;
        push       = '0;
        if (o_take) begin
            if (!r_in_frame) begin
                if (r_prev_ff && is_soi) begin
                    push.cnt             = 2'd2;
                    push.r0.frame_byte   = BYTE_FF;
                    push.r0.byte_valid   = 1'b1;
                    push.r0.frame_start  = 1'b1;
                    push.r1.frame_byte   = i_byte;
                    push.r1.byte_valid   = 1'b1;
                    push.r1.last_of_step = 1'b1;
                    n_in_frame           = 1'b1;
                    n_prev_ff            = 1'b0;
                    n_len                = LEN_SOI;
                end else begin
                    n_prev_ff = is_ff;
                end
            end else begin
                push.cnt             = 2'd1;
                push.r0.frame_byte   = i_byte;
                push.r0.byte_valid   = 1'b1;
                push.r0.frame_end    = ends;
                push.r0.last_of_step = 1'b1;
                n_len                = len_inc;
                if (ends) begin
                    n_in_frame = 1'b0;
                    n_prev_ff  = 1'b0;
                    n_len      = '0;
                end else begin
                    n_prev_ff = is_ff;
                    // overflow before the end marker: abort follows the byte
                    if (len_inc > {1'b0, r_limit}) begin
                        push.cnt             = 2'd2;
                        push.r0.last_of_step = 1'b0;
                        push.r1.frame_abort  = 1'b1;
                        push.r1.last_of_step = 1'b1;
                        n_in_frame           = 1'b0;
                        n_prev_ff            = 1'b0;
                        n_len                = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_prev_ff  <= 1'b0;
            r_len      <= '0;
            r_limit    <= LIMIT_RESET;
        end else begin
            r_in_frame <= n_in_frame;
            r_prev_ff  <= n_prev_ff;
            r_len      <= n_len;
            r_limit    <= n_limit;
        end
    end

    assign o_push = push;

endmodule

>>> src/mfd_out_queue.sv
// result queue of the mjpeg frame delimiter, shift style, three entries
// head entry drives the master stream; uses mfd_pkg
module mfd_out_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mfd_pkg::t_push i_push,
    output logic           o_space_ok,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [7:0]     o_tdata,
    output logic [3:0]     o_tuser,
    output logic           o_tlast
);
    import mfd_pkg::*;

    t_result    r_q [QUEUE_DEPTH];
    t_result    n_q [QUEUE_DEPTH];
    logic [1:0] r_count, n_count;
    logic [1:0] base;
    logic       pop;

    assign pop        = (r_count != 2'd0) && i_tready;
    assign base       = r_count - {1'b0, pop};
    // room for two results without counting on a pop
    assign o_space_ok = (r_count <= 2'd1);

    // shift on pop, then append new results behind the survivors
    always_comb begin
        n_q = r_q;
        if (pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ((i_push.cnt != 2'd0) && (base == 2'(i))) begin
                n_q[i] = i_push.r0;
            end
            if ((i_push.cnt == 2'd2) && (base + 2'd1 == 2'(i))) begin
                n_q[i] = i_push.r1;
            end
        end
        n_count = base + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_tvalid = (r_count != 2'd0);
    assign o_tdata  = r_q[0].frame_byte;
    assign o_tuser  = {r_q[0].last_of_step, r_q[0].frame_abort,
                       r_q[0].frame_start, r_q[0].byte_valid};
    assign o_tlast  = r_q[0].frame_end;

endmodule

>>> src/mjpeg_frame_delimiter_top.sv
// top level of the mjpeg frame delimiter
// instantiates mfd_in_reg, mfd_core and mfd_out_queue; uses mfd_pkg
//
// Usage:
//   Slave stream s_axis carries one raw byte of a Motion-JPEG stream per item.
//   Master stream m_axis carries frame bytes: tdata is the byte, tlast marks
//   the D9 of the end marker, tuser flags valid byte, frame start, abort and
//   last result of the input byte. A frame runs from FF D8 through FF D9; bytes
//   between frames are dropped. A frame that grows past the frame size limit
//   before its end marker gets an abort item (byte_valid low) and is dropped.
//   The user must write the limit through i_cfg_wr_en / i_cfg_wr_data
//   only while idle; the block does not enforce this.
// Throughput: one byte per cycle while m_axis_tready is high; a byte that yields
//   two results (start marker D8, or the overflowing byte with its abort)
//   holds up the input, since one result leaves m_axis per cycle and a byte is
//   only taken while the queue has two free entries.
// Reset: synchronous, active low; clears frame state, empties the queue and
//   sets the limit to 1048576 bytes.
// Stall: the output queue holds results while m_axis_tready is low; input
//   keeps being taken until the queue has fewer than two free entries.
module mjpeg_frame_delimiter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [mfd_pkg::LIMIT_W-1:0] i_cfg_wr_data,   // frame size limit
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,    // [7:0] data_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,    // [7:0] frame_byte
    // [0] byte_valid, [1] frame_start, [2] frame_abort, [3] last_of_step
    output logic [3:0]                  m_axis_tuser,
    output logic                        m_axis_tlast     // frame_end
);
    import mfd_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       take;
    logic       space_ok;
    t_push      push;

    // input register
    mfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    // marker and length logic
    mfd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (in_valid),
        .i_byte        (in_byte),
        .i_space_ok    (space_ok),
        .o_take        (take),
        .o_push        (push)
    );

    // result queue
    mfd_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser),
        .o_tlast    (m_axis_tlast)
    );

endmodule

>>> src/mfd_checker.sv
// port-level checks for the mjpeg frame delimiter, bound to the top level
// uses mfd_pkg and the macros of mjpeg_frame_delimiter_top_assert.svh
`include "mjpeg_frame_delimiter_top_assert.svh"

module mfd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_wr_en,
    input logic [mfd_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [7:0]                  s_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [7:0]                  m_axis_tdata,
    input logic [3:0]                  m_axis_tuser,
    input logic                        m_axis_tlast
);
    import mfd_pkg::*;

    // stalled result item holds
    `MFD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // abort item carries no byte and closes its input byte
    `MFD_ASSERT(a_abort_form, m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tuser[0] && (m_axis_tdata == 8'h00) && !m_axis_tlast && m_axis_tuser[3])

    // start item is the FF of the marker and the D8 item follows it
    `MFD_ASSERT(a_start_form, m_axis_tvalid && m_axis_tready && m_axis_tuser[1] |-> (m_axis_tdata == BYTE_FF) && m_axis_tuser[0] && !m_axis_tuser[3] ##1 m_axis_tvalid && (m_axis_tdata == BYTE_SOI))

    // frame end is the D9 and the only result of its byte
    `MFD_ASSERT(a_end_form, m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata == BYTE_EOI) && m_axis_tuser[0] && m_axis_tuser[3])

    // no result right after reset
    `MFD_ASSERT_NORST(a_reset_empty, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind mjpeg_frame_delimiter_top mfd_checker u_mfd_checker (.*);

>>> sim/tb_top.sv
// testbench for mjpeg_frame_delimiter_top: byte stream in, framed result items out
// self-checking against an in-bench frame predictor; depends on mfd_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
    import mfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]   i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic [3:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    mjpeg_frame_delimiter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // stream bytes waiting to be sent, and result items still owed by the block
    logic [7:0] stream_bytes_pending[$];
    t_result    frame_results_due[$];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  drain_hold = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    // predictor copy of the block state and its limit register
    logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;
    logic               model_in_frame = 1'b0;
    logic               model_prev_ff = 1'b0;
    logic [LEN_W-1:0]   model_frame_len = '0;

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // append one byte to the send queue
    task automatic queue_byte(input logic [7:0] b);
        stream_bytes_pending = {stream_bytes_pending, b};
    endtask

    // work out the result items one accepted byte causes
    task automatic predict_frame_results(input logic [7:0] b);
        logic [LEN_W-1:0] eff_limit;
        t_result          r0;
        t_result          r1;
        int               n;
        bit               ends;
        eff_limit = (model_limit < LIMIT_MIN) ? LEN_W'(LIMIT_MIN) : LEN_W'(model_limit);
        r0 = '0;
        r1 = '0;
        n = 0;
        if (!model_in_frame) begin
            if (model_prev_ff && b == BYTE_SOI) begin
                r0.frame_byte  = BYTE_FF;
                r0.byte_valid  = 1'b1;
                r0.frame_start = 1'b1;
                r1.frame_byte  = b;
                r1.byte_valid  = 1'b1;
                n = 2;
                model_in_frame  = 1'b1;
                model_prev_ff   = 1'b0;
                model_frame_len = LEN_SOI;
            end else begin
                model_prev_ff = (b == BYTE_FF);
            end
        end else begin
            ends = model_prev_ff && b == BYTE_EOI;
            r0.frame_byte = b;
            r0.byte_valid = 1'b1;
            r0.frame_end  = ends;
            n = 1;
            if (model_frame_len < LEN_MAX) model_frame_len = model_frame_len + 1'b1;
            if (ends) begin
                model_in_frame  = 1'b0;
                model_prev_ff   = 1'b0;
                model_frame_len = '0;
            end else begin
                model_prev_ff = (b == BYTE_FF);
                // limit only counts while no end marker has come
                if (model_frame_len > eff_limit) begin
                    r1.frame_abort = 1'b1;
                    n = 2;
                    model_in_frame  = 1'b0;
                    model_prev_ff   = 1'b0;
                    model_frame_len = '0;
                end
            end
        end
        if (n == 1) r0.last_of_step = 1'b1;
        if (n == 2) r1.last_of_step = 1'b1;
        if (n >= 1) frame_results_due = {frame_results_due, r0};
        if (n == 2) frame_results_due = {frame_results_due, r1};
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // driver: present the next pending byte unless idling or holding off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // item still waiting for acceptance, keep it
        end else if (stream_bytes_pending.size() > 0 && !drain_hold &&
                     $urandom_range(99) >= send_idle_pct) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stream_bytes_pending.pop_front();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_frame_results(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.frame_byte   = m_axis_tdata;
                got.byte_valid   = m_axis_tuser[0];
                got.frame_start  = m_axis_tuser[1];
                got.frame_abort  = m_axis_tuser[2];
                got.last_of_step = m_axis_tuser[3];
                got.frame_end    = m_axis_tlast;
                if (frame_results_due.size() == 0) begin
                    $error("unexpected result item: byte %0h user %0h last %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = frame_results_due.pop_front();
                    check_field("frame_byte", want.frame_byte, got.frame_byte);
                    check_field("byte_valid", want.byte_valid, got.byte_valid);
                    check_field("frame_start", want.frame_start, got.frame_start);
                    check_field("frame_end", want.frame_end, got.frame_end);
                    check_field("frame_abort", want.frame_abort, got.frame_abort);
                    check_field("last_of_step", want.last_of_step, got.last_of_step);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_limit = value;
        @(negedge i_clk);
    endtask

    task automatic push_bytes(input logic [7:0] seq[]);
        foreach (seq[i]) queue_byte(seq[i]);
    endtask

    // wait until every byte is taken and every result has come, then settle
    task automatic wait_for_drain();
        while (stream_bytes_pending.size() > 0 || s_axis_tvalid ||
               frame_results_due.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] body_byte();
        return ($urandom_range(5) == 0) ? BYTE_FF : 8'($urandom_range(255));
    endfunction

    // mostly well-formed frames with random content, plus noise and broken frames
    task automatic add_random_stream(input int target);
        int start_size;
        int kind;
        int body_len;
        int junk_len;
        start_size = stream_bytes_pending.size();
        while (stream_bytes_pending.size() - start_size < target) begin
            kind = $urandom_range(9);
            if (kind <= 6 || kind == 9) begin
                junk_len = $urandom_range(3);
                repeat (junk_len) queue_byte(body_byte());
                if ($urandom_range(3) == 0) queue_byte(BYTE_FF);
                queue_byte(BYTE_FF);
                queue_byte(BYTE_SOI);
                if (model_limit <= 300)
                    body_len = $urandom_range(int'(model_limit) + 2);
                else if ($urandom_range(9) == 0)
                    body_len = $urandom_range(200);
                else
                    body_len = $urandom_range(24);
                for (int i = 0; i < body_len; i++) begin
                    // a start marker inside the frame now and then
                    if (kind == 9 && i == body_len / 2) begin
                        queue_byte(BYTE_FF);
                        queue_byte(BYTE_SOI);
                    end
                    queue_byte(body_byte());
                end
                queue_byte(BYTE_FF);
                queue_byte(BYTE_EOI);
            end else if (kind == 7) begin
                junk_len = 1 + $urandom_range(7);
                repeat (junk_len) queue_byte(body_byte());
            end else begin
                // start marker followed by a frame that never ends properly
                queue_byte(BYTE_FF);
                queue_byte(BYTE_SOI);
                body_len = $urandom_range(6);
                repeat (body_len) queue_byte(body_byte());
                queue_byte(BYTE_FF);
                queue_byte(8'($urandom_range(BYTE_EOI - 1)));
            end
        end
    endtask

    // stimulus sequencing
    initial begin
        logic [LIMIT_W-1:0] rand_limits[8];
        int                 half;
        rand_limits[0] = LIMIT_MIN;
        rand_limits[1] = '0;
        rand_limits[2] = 24'hFFFFFF;
        rand_limits[3] = LIMIT_W'($urandom_range(40, 3));
        rand_limits[4] = 24'd1;
        rand_limits[5] = LIMIT_W'($urandom_range(300, 41));
        rand_limits[6] = LIMIT_RESET;
        rand_limits[7] = LIMIT_W'($urandom_range(16, 2));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // repeated ff while hunting, start marker inside a frame, ff d8 d9
        send_idle_pct = 0;
        stall_pct = 0;
        push_bytes('{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hD8, 8'h7F, 8'hFF, 8'hD8,
                     8'hD9, 8'h00, 8'hFF, 8'hD9, 8'hFF, 8'hD8, 8'hD9, 8'h80});
        wait_for_drain();

        // limit lowered below two while a frame is open
        write_limit('0);
        push_bytes('{8'h55, 8'hFF, 8'hD8, 8'h33});
        wait_for_drain();

        // end marker on the overflowing byte, then held ff cleared by abort
        write_limit(24'd3);
        push_bytes('{8'hFF, 8'hD8, 8'hFF, 8'hD9, 8'hFF, 8'hD8, 8'h00, 8'hFF, 8'hD8});
        wait_for_drain();

        for (int p = 0; p < 8; p++) begin
            write_limit(rand_limits[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            add_random_stream(206);
            if (p % 2 == 1) begin
                // hold the sender mid-phase until the block has caught up
                half = stream_bytes_pending.size() / 2;
                while (stream_bytes_pending.size() > half) @(negedge i_clk);
                drain_hold = 1'b1;
                while (s_axis_tvalid || frame_results_due.size() > 0) @(negedge i_clk);
                repeat (3) @(negedge i_clk);
                drain_hold = 1'b0;
            end
            wait_for_drain();
        end

        if (mismatch_count == 0 && frame_results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
